// ===== rtl/core/wis_pkg.sv =====
package wis_pkg;

    // Table geometry and arithmetic widths.
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS      = IDX_BITS + 1;
    localparam int WEIGHT_BITS   = 16;
    localparam int SUM_BITS      = 24;
    localparam int U_BITS        = 32;
    localparam int OUT_BITS      = 8;
    localparam int COL_BITS      = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;
    localparam int DIV_CNT_BITS  = $clog2(IDX_BITS);

    // Action codes of an input word.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_WITH_REPL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COL_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0]             action;
        logic [WEIGHT_BITS-1:0] weight;
        logic [U_BITS-1:0]      uniform;
    } t_in_word;

    typedef struct packed {
        logic [OUT_BITS-1:0] row;
        logic [OUT_BITS-1:0] column;
        logic [OUT_BITS-1:0] flat_index;
        logic                empty_res;
    } t_res_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic capture;
        logic mul;
        logic srch_rd;
        logic srch_cmp;
        logic walk_init;
        logic walk;
        logic div_init;
        logic div_step;
        logic emit;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic srch_done;
        logic walk_done;
        logic div_done;
    } t_dp_stat;

endpackage

// ===== rtl/core/weighted_index_sampler_top.sv =====
// Weighted index sampler: draws a table index with probability in proportion to its
// integer weight, by inverse cumulative search over a table of running sums.
// Input channel: a word (action, weight, uniform) is taken at a clock edge where start
// is high and busy is low. Loads and clears finish at that edge and busy stays low, so
// one may follow every cycle. A draw with nothing left answers with an empty word in
// the next cycle, also without raising busy.
// Any other draw holds busy high through a product step, s binary search steps (s being
// at most ceil(log2(n)) for n loaded entries), each a registered table read and then the
// compare, a step in which the search ends, the bit-serial divider that splits the index
// into row and column, and a step to register the result. Without replacement a tail
// walk comes before the divider, m being the drawn index: one read and one write-back per
// cycle from entry m on, then the last write and the hand-over to the divider. The result
// word appears on o_res, marked by o_res_strobe for one cycle, in the first cycle in which
// busy is low again; the receiver cannot stall it.
// Configuration: a write channel that is always ready; index 0 selects drawing with
// replacement (bit 0), index 1 the column count (zero acts as one). Write only while
// the block is idle. Reset clears the entry count, the totals and the draw counter and
// restores the register defaults; the table itself is left as it is.
module weighted_index_sampler_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  wis_pkg::t_in_word                     i_in,
    output logic                                  o_res_strobe,
    output wis_pkg::t_res_word                    o_res,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wis_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [wis_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import wis_pkg::*;

    logic                r_with_repl;
    logic [COL_BITS-1:0] r_col_count;
    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic                ctrl_busy;

    // The configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_with_repl <= 1'b1;
            r_col_count <= COL_BITS'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WITH_REPL: r_with_repl <= i_cfg_data[0];
                CFG_COL_COUNT: r_col_count <= COL_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // The controller sequences each draw; it sees an item only when it is idle.
    wis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_action    (i_in.action),
        .i_with_repl (r_with_repl),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .busy        (ctrl_busy)
    );

    // The datapath holds the cumulative table, the totals, the search bounds, the
    // tail walk and the divider, plus the result register.
    wis_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cmd        (dp_cmd),
        .i_col_count  (r_col_count),
        .o_stat       (dp_stat),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    assign busy = ctrl_busy;

endmodule

// ===== rtl/core/wis_ctrl.sv =====
module wis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_action,
    input  logic              i_with_repl,
    input  wis_pkg::t_dp_stat i_stat,
    output wis_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import wis_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL      = 7'b0000010,
        S_SRCH_RD  = 7'b0000100,
        S_SRCH_CMP = 7'b0001000,
        S_WALK     = 7'b0010000,
        S_DIV      = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_action)
                        ACT_LOAD:  o_cmd.load  = 1'b1;
                        ACT_CLEAR: o_cmd.clear = 1'b1;
                        ACT_DRAW: begin
                            if (i_stat.empty) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                o_cmd.capture = 1'b1;
                                n_state       = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                if (!i_stat.srch_done) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = S_SRCH_CMP;
                end else if (!i_with_repl) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = S_SRCH_RD;
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // Walk never meets divide or emit; DONE ends in idle; capture leads to mul.
    a_walk_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.walk || o_cmd.walk_init) |-> !o_cmd.div_step && !o_cmd.emit)
        else $error("walk command overlaps division or emit");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> !busy)
        else $error("controller did not return to idle after a result");
    a_capture_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.mul)
        else $error("captured draw not followed by the product step");

endmodule

// ===== rtl/core/wis_dp.sv =====
module wis_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wis_pkg::t_in_word                   i_in,
    input  wis_pkg::t_dp_cmd                    i_cmd,
    input  logic [wis_pkg::COL_BITS-1:0]        i_col_count,
    output wis_pkg::t_dp_stat                   o_stat,
    output logic                                o_res_strobe,
    output wis_pkg::t_res_word                  o_res
);
    import wis_pkg::*;

    logic [SUM_BITS-1:0] r_mem [TABLE_ENTRIES];

    logic [CNT_BITS-1:0]     r_n;
    logic [SUM_BITS-1:0]     r_total;
    logic [SUM_BITS-1:0]     r_draws;
    logic [U_BITS-1:0]       r_u;
    logic [SUM_BITS-1:0]     r_rem_cap;
    logic [SUM_BITS-1:0]     r_thr;
    logic [IDX_BITS-1:0]     r_lo;
    logic [IDX_BITS-1:0]     r_hi;
    logic [IDX_BITS-1:0]     r_mid;
    logic [SUM_BITS-1:0]     r_rdata;
    logic [CNT_BITS-1:0]     r_idx;
    logic                    r_pend;
    logic [IDX_BITS-1:0]     r_wr_addr;
    logic [IDX_BITS-1:0]     r_dvd;
    logic [COL_BITS-1:0]     r_rmd;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    t_res_word               r_res;
    logic                    r_res_strobe;

    logic [SUM_BITS:0]          load_sum;
    logic [SUM_BITS-1:0]        new_total;
    logic [SUM_BITS-1:0]        remaining;
    logic [SUM_BITS+U_BITS-1:0] product;
    logic [IDX_BITS:0]          mid_sum;
    logic [IDX_BITS-1:0]        mid;
    logic                       walk_issue;
    logic                       rd_en;
    logic [IDX_BITS-1:0]        rd_addr;
    logic                       wr_en;
    logic [IDX_BITS-1:0]        wr_addr;
    logic [SUM_BITS-1:0]        wr_data;
    logic [COL_BITS-1:0]        divisor;
    logic [COL_BITS:0]          trial;
    logic                       trial_ge;
    logic                       can_load;

    always_comb begin
        load_sum  = {1'b0, r_total} + (SUM_BITS+1)'(i_in.weight);
        new_total = load_sum[SUM_BITS] ? {SUM_BITS{1'b1}} : load_sum[SUM_BITS-1:0];
        remaining = r_total - r_draws;
        product   = (SUM_BITS+U_BITS)'(r_u) * (SUM_BITS+U_BITS)'(r_rem_cap);
        mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
        mid       = mid_sum[IDX_BITS:1];
        can_load  = (r_n < CNT_BITS'(TABLE_ENTRIES));
        walk_issue = (r_idx < r_n);
        divisor   = (i_col_count == '0) ? COL_BITS'(1) : i_col_count;
        trial     = {r_rmd, r_dvd[IDX_BITS-1]};
        trial_ge  = (trial >= {1'b0, divisor});
    end

    // One read port shared by the search and the tail walk; one write port shared
    // by loading and the walk's write-back.
    always_comb begin
        rd_en   = i_cmd.srch_rd || (i_cmd.walk && walk_issue);
        rd_addr = i_cmd.srch_rd ? mid : r_idx[IDX_BITS-1:0];
        if (i_cmd.load && can_load) begin
            wr_en   = 1'b1;
            wr_addr = r_n[IDX_BITS-1:0];
            wr_data = new_total - r_draws;
        end else begin
            wr_en   = i_cmd.walk && r_pend;
            wr_addr = r_wr_addr;
            wr_data = (r_rdata != '0) ? r_rdata - 1'b1 : r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= '0;
            r_total      <= '0;
            r_draws      <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_pend       <= 1'b0;
            r_idx        <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= i_cmd.emit || i_cmd.emit_empty;
            if (i_cmd.clear) begin
                r_n     <= '0;
                r_total <= '0;
                r_draws <= '0;
            end
            if (i_cmd.load && can_load) begin
                r_total <= new_total;
                r_n     <= r_n + 1'b1;
            end
            if (i_cmd.mul) begin
                r_lo <= '0;
                r_hi <= IDX_BITS'(r_n - 1'b1);
            end
            if (i_cmd.srch_cmp) begin
                if (r_rdata > r_thr) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= IDX_BITS'(r_mid + 1'b1);
                end
            end
            if (i_cmd.walk_init) begin
                r_idx   <= {1'b0, r_lo};
                r_pend  <= 1'b0;
                r_draws <= r_draws + 1'b1;
            end
            if (i_cmd.walk) begin
                r_pend <= walk_issue;
                if (walk_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_u       <= i_in.uniform;
            r_rem_cap <= remaining;
        end
        if (i_cmd.mul) begin
            r_thr <= product[SUM_BITS+U_BITS-1:U_BITS];
        end
        if (i_cmd.srch_rd) begin
            r_mid <= mid;
        end
        if (i_cmd.walk && walk_issue) begin
            r_wr_addr <= r_idx[IDX_BITS-1:0];
        end
        if (i_cmd.div_init) begin
            r_dvd     <= r_lo;
            r_rmd     <= '0;
            r_div_cnt <= DIV_CNT_BITS'(IDX_BITS - 1);
        end
        if (i_cmd.div_step) begin
            r_rmd     <= trial_ge ? COL_BITS'(trial - {1'b0, divisor}) : COL_BITS'(trial);
            r_dvd     <= {r_dvd[IDX_BITS-2:0], trial_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.emit) begin
            r_res.row        <= OUT_BITS'(r_dvd);
            r_res.column     <= OUT_BITS'(r_rmd);
            r_res.flat_index <= OUT_BITS'(r_lo);
            r_res.empty_res  <= 1'b0;
        end else if (i_cmd.emit_empty) begin
            r_res.row        <= '0;
            r_res.column     <= '0;
            r_res.flat_index <= '0;
            r_res.empty_res  <= 1'b1;
        end
    end

    assign o_stat.empty     = (r_n == '0) || (remaining == '0);
    assign o_stat.srch_done = (r_lo == r_hi);
    assign o_stat.walk_done = !walk_issue && !r_pend;
    assign o_stat.div_done  = (r_div_cnt == '0);
    assign o_res_strobe     = r_res_strobe;
    assign o_res            = r_res;

    a_draws_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draws <= r_total)
        else $error("more draws taken than weight loaded");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("search bounds crossed");
    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && r_pend) |-> ({1'b0, r_wr_addr} < r_n))
        else $error("tail walk writes beyond the loaded entries");

endmodule

// ===== verif/weighted_index_sampler_top_tb.sv =====
module weighted_index_sampler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wis_pkg::*;

    // The package names the three defined actions; the fourth code is accepted and ignored.
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Register indexes with no register behind them; writes to them must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    localparam int MAX_GAP       = 18;
    localparam int ITEM_TARGET   = 800;
    localparam int SETTLE_CYCLES = 8;
    // A full table drawn without replacement keeps busy high the longest, so
    // the tail wait covers one such draw after the last result.
    localparam int TAIL_CYCLES   = 300;
    // The longest correct stretch with no handshake is one such draw followed by the
    // longest sender gap; QUIET_LIMIT is set above that.
    localparam int QUIET_LIMIT   = 3000;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    t_in_word                  i_in        = '0;
    logic                      o_res_strobe;
    t_res_word                 o_res;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    weighted_index_sampler_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Words waiting to be offered, and the draw results that the table says must come.
    t_in_word  pending_q [$];
    t_res_word drawn_q [$];

    int unsigned items_queued = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left     = 0;
    bit          no_idle      = 1'b0;

    // Our own copy of the sampler's state. Entries above tbl_entries are never read, so
    // the table needs no reset value.
    logic [SUM_BITS-1:0]  tbl_cum [TABLE_ENTRIES];
    int unsigned          tbl_entries   = 0;
    logic [SUM_BITS-1:0]  tbl_total     = '0;
    logic [SUM_BITS-1:0]  tbl_draws     = '0;
    logic                 cfg_with_repl = 1'b1;
    logic [COL_BITS-1:0]  cfg_columns   = 9'd16;

    // Applies one accepted word to the table copy. A draw leaves its expected result at
    // the back of drawn_q; loads, clears and the idle code leave nothing.
    function automatic void apply_word(input t_in_word w);
        logic [SUM_BITS:0]   sum;
        logic [SUM_BITS-1:0] remaining;
        logic [63:0]         target;
        int unsigned         pick;
        int unsigned         cols;
        int unsigned         i;
        int unsigned         row_i;
        int unsigned         col_i;
        bit                  found;
        t_res_word           res;
        case (w.action)
            ACT_LOAD: begin
                // A load into a full table is dropped without any change of state.
                if (tbl_entries < TABLE_ENTRIES) begin
                    sum = {1'b0, tbl_total} + (SUM_BITS+1)'(w.weight);
                    // The loaded total saturates rather than wraps.
                    tbl_total = sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
                    // The new running sum builds on whatever earlier draws have removed.
                    tbl_cum[tbl_entries] = tbl_total - tbl_draws;
                    tbl_entries++;
                end
            end
            ACT_DRAW: begin
                res = '0;
                remaining = tbl_total - tbl_draws;
                if (tbl_entries == 0 || remaining == 0) begin
                    res.empty_res = 1'b1;
                end else begin
                    // First entry whose running sum, scaled by 2^32, exceeds u times the
                    // remaining total. The last entry always equals the remaining total,
                    // so the search never falls through in practice.
                    target = {32'd0, w.uniform} * {40'd0, remaining};
                    pick   = tbl_entries - 1;
                    found  = 1'b0;
                    for (i = 0; i < tbl_entries && !found; i++) begin
                        if ({8'd0, tbl_cum[i], 32'd0} > target) begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                    if (!cfg_with_repl) begin
                        // Taking one unit from the chosen entry lowers every running sum
                        // from there to the end of the loaded part.
                        for (i = pick; i < tbl_entries; i++) begin
                            if (tbl_cum[i] != 0)
                                tbl_cum[i] = tbl_cum[i] - 1'b1;
                        end
                        tbl_draws = tbl_draws + 1'b1;
                    end
                    // A column count of zero behaves as one.
                    cols  = (cfg_columns == 0) ? 1 : int'(cfg_columns);
                    row_i = pick / cols;
                    col_i = pick % cols;
                    res.row        = row_i[OUT_BITS-1:0];
                    res.column     = col_i[OUT_BITS-1:0];
                    res.flat_index = pick[OUT_BITS-1:0];
                end
                drawn_q.push_back(res);
            end
            ACT_CLEAR: begin
                tbl_entries = 0;
                tbl_total   = '0;
                tbl_draws   = '0;
            end
            default: begin
            end
        endcase
    endfunction

    // Driver. A word is taken at an edge where start is high and busy is low. Straight
    // after that edge the next word is either offered at once, keeping start high with no
    // dip, or start drops for a randomly drawn gap. Now and then the gaps switch off for
    // a stretch so that words also arrive back to back.
    always @(posedge i_clk) begin
        int unsigned gap;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            apply_word(i_in);
            if ($urandom_range(0, 29) == 0)
                no_idle <= !no_idle;
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap == 0 && pending_q.size() != 0) begin
                i_in <= pending_q.pop_front();
            end else begin
                start    <= 1'b0;
                gap_left <= (gap == 0) ? 0 : gap - 1;
            end
        end else if (!start) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_q.size() != 0) begin
                start <= 1'b1;
                i_in  <= pending_q.pop_front();
            end
        end
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor. The block cannot be stalled, so every strobe is a result word taken at
    // that edge and is matched against the oldest expected draw.
    always @(posedge i_clk) begin
        t_res_word want;
        if (i_rst_n && o_res_strobe === 1'b1) begin
            if (drawn_q.size() == 0) begin
                $error("result word with none expected: row %0d column %0d flat %0d empty %0d",
                       o_res.row, o_res.column, o_res.flat_index, o_res.empty_res);
                fail_count++;
            end else begin
                want = drawn_q.pop_front();
                compare_field("row", want.row, o_res.row);
                compare_field("column", want.column, o_res.column);
                compare_field("flat_index", want.flat_index, o_res.flat_index);
                compare_field("empty_res", want.empty_res, o_res.empty_res);
            end
        end
    end

    // Watchdog: counts the cycles in which no handshake of any kind completes.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe === 1'b1 || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("weighted_index_sampler_top_tb failed");
        $finish;
    end

    // Stimulus helpers. Unused fields of a word carry random bits so that every bit of
    // the input word toggles.
    task automatic queue_word(input logic [1:0] action, input logic [WEIGHT_BITS-1:0] weight,
                              input logic [U_BITS-1:0] uniform, input bit counts);
        t_in_word w;
        w.action  = action;
        w.weight  = weight;
        w.uniform = uniform;
        pending_q.push_back(w);
        if (counts)
            items_queued++;
    endtask

    task automatic queue_load(input logic [WEIGHT_BITS-1:0] weight);
        queue_word(ACT_LOAD, weight, $urandom, 1'b1);
    endtask

    task automatic queue_draw(input logic [U_BITS-1:0] uniform);
        queue_word(ACT_DRAW, WEIGHT_BITS'($urandom), uniform, 1'b1);
    endtask

    task automatic queue_clear();
        queue_word(ACT_CLEAR, WEIGHT_BITS'($urandom), $urandom, 1'b1);
    endtask

    // Weights lean towards small values so that drawing without replacement really does
    // run tables dry, while full-scale and zero weights still turn up.
    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return WEIGHT_BITS'($urandom_range(1, 3));
            4:       return '1;
            5, 6:    return WEIGHT_BITS'($urandom_range(0, 255));
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [U_BITS-1:0] rand_uniform();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Occasional noise between the words of a sequence: the ignored action code, or a
    // stray clear that breaks the sequence off.
    task automatic maybe_noise();
        if ($urandom_range(0, 15) == 0)
            queue_word(ACT_NONE, WEIGHT_BITS'($urandom), $urandom, 1'b0);
        else if ($urandom_range(0, 59) == 0)
            queue_clear();
    endtask

    // One well-formed sequence: usually a clear, a run of loads, a run of draws, and at
    // times a few more loads on top of the depleted table followed by further draws.
    task automatic build_sequence();
        int unsigned n_load;
        if ($urandom_range(0, 3) != 0)
            queue_clear();
        n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        repeat (n_load) begin
            queue_load(rand_weight());
            maybe_noise();
        end
        repeat ($urandom_range(4, 24)) begin
            queue_draw(rand_uniform());
            maybe_noise();
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4))
                queue_load(rand_weight());
            repeat ($urandom_range(2, 8))
                queue_draw(rand_uniform());
        end
    endtask

    // Waits until every word has been taken, the block is idle and no draw is still
    // owed, then lets settle more cycles pass so that a stray result would be seen.
    task automatic drain(input int unsigned settle);
        do @(posedge i_clk);
        while (pending_q.size() != 0 || start || busy || drawn_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Register write; the table copy follows the write at the edge where it lands.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_WITH_REPL: cfg_with_repl = data[0];
            CFG_COL_COUNT: cfg_columns   = data;
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_mode(input bit with_repl);
        logic [CFG_DATA_BITS-1:0] d;
        d    = CFG_DATA_BITS'($urandom);
        d[0] = with_repl;
        write_reg(CFG_WITH_REPL, d);
    endtask

    // The opening phases visit the extreme column counts, including zero and one.
    function automatic logic [COL_BITS-1:0] column_setting(input int unsigned phase);
        case (phase)
            0:       return 9'd1;
            1:       return 9'd256;
            2:       return 9'd1;
            3:       return 9'd0;
            4:       return 9'd255;
            5:       return 9'd3;
            default: begin
                if ($urandom_range(0, 5) == 0)
                    return COL_BITS'($urandom_range(0, 511));
                return COL_BITS'($urandom_range(1, 256));
            end
        endcase
    endfunction

    // Directed opening under the reset settings: empty table, a zero total, extreme
    // fractions, zero weights, the ignored code, a row above zero and a clear.
    task automatic run_directed();
        queue_draw('0);
        queue_word(ACT_NONE, '1, '1, 1'b0);
        queue_load('0);
        queue_draw('1);
        queue_load('1);
        queue_load(16'd1);
        queue_load('0);
        queue_load('1);
        queue_draw('0);
        queue_draw('1);
        queue_draw(32'h8000_0000);
        repeat (11)
            queue_load(rand_weight());
        queue_load('1);
        queue_draw('1);
        queue_clear();
        queue_draw('0);
    endtask

    // Fills the table to the last entry, tries to load past the end, and draws from the
    // full table first without and then with replacement. The table survives the
    // register writes in between.
    task automatic run_full_table();
        queue_clear();
        repeat (TABLE_ENTRIES)
            queue_load(rand_weight());
        repeat (3)
            queue_word(ACT_LOAD, rand_weight(), $urandom, 1'b0);
        repeat (15)
            queue_draw(rand_uniform());
        drain(SETTLE_CYCLES);
        write_reg(CFG_COL_COUNT, 9'd256);
        write_mode(1'b1);
        repeat (30) begin
            queue_draw(rand_uniform());
            maybe_noise();
        end
    endtask

    initial begin
        int unsigned phase;
        bit          with_repl;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain(SETTLE_CYCLES);

        // Random phases, each under its own settings. Every phase ends with a full
        // drain, so the sender regularly holds off until all results are in.
        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            with_repl = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            write_mode(with_repl);
            write_reg(CFG_COL_COUNT, column_setting(phase));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          CFG_DATA_BITS'($urandom));
            if (phase == 2) begin
                run_full_table();
            end else begin
                repeat ($urandom_range(3, 6))
                    build_sequence();
            end
            drain(SETTLE_CYCLES);
            phase++;
        end

        drain(TAIL_CYCLES);
        if (fail_count == 0)
            $display("weighted_index_sampler_top_tb passed");
        else
            $display("weighted_index_sampler_top_tb failed");
        $finish;
    end

endmodule
